@@ rtl/hfc_pkg.sv @@
`timescale 1ns / 1ps

package hfc_pkg;

    // Debounce and lockout timing, in ticks.
    localparam int SETTLE_W = 4;
    localparam int SINCE_W  = 6;
    localparam logic [SETTLE_W-1:0] SETTLE_TICKS  = 4'd10;
    localparam logic [SINCE_W-1:0]  LOCKOUT_TICKS = 6'd50;

    // Field widths.
    localparam int HUM_W   = 14;
    localparam int THR_W   = 15;
    localparam int HYST_W  = 14;
    localparam int DUR_W   = 27;
    localparam int DOOR_W  = 2;

    // Door code that means the door is open.
    localparam logic [DOOR_W-1:0] DOOR_OPEN = 2'd2;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_ON_THRESHOLD = 2'd0;
    localparam logic [1:0] REG_HYSTERESIS   = 2'd1;
    localparam logic [1:0] REG_MANUAL_DUR   = 2'd2;

    // Reset values of the registers.
    localparam logic signed [THR_W-1:0] ON_THRESHOLD_RST = 15'sd100;
    localparam logic [HYST_W-1:0]       HYSTERESIS_RST   = 14'd40;
    localparam logic [DUR_W-1:0]        MANUAL_DUR_RST   = 27'd1800000;

    typedef struct packed {
        logic signed [THR_W-1:0] on_threshold;
        logic [HYST_W-1:0]       hysteresis;
        logic [DUR_W-1:0]        manual_duration_ms;
    } cfg_t;

    typedef struct packed {
        logic [HUM_W-1:0]  inside_humidity;
        logic [HUM_W-1:0]  outside_humidity;
        logic              readings_valid;
        logic [DOOR_W-1:0] door_status;
        logic              button_level;
    } item_t;

    typedef struct packed {
        logic send_request;
        logic manual_mode;
        logic fan_on;
    } result_t;

endpackage

@@ rtl/hfc_cfg_regs.sv @@
`timescale 1ns / 1ps

module hfc_cfg_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output hfc_pkg::cfg_t      cfg
);

    hfc_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Register writes complete in the access phase.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.on_threshold       <= hfc_pkg::ON_THRESHOLD_RST;
            cfg_reg.hysteresis         <= hfc_pkg::HYSTERESIS_RST;
            cfg_reg.manual_duration_ms <= hfc_pkg::MANUAL_DUR_RST;
        end else if (wr_en) begin
            unique case (paddr[3:2])
                hfc_pkg::REG_ON_THRESHOLD: begin
                    cfg_reg.on_threshold <= pwdata[hfc_pkg::THR_W-1:0];
                end
                hfc_pkg::REG_HYSTERESIS: begin
                    cfg_reg.hysteresis <= pwdata[hfc_pkg::HYST_W-1:0];
                end
                hfc_pkg::REG_MANUAL_DUR: begin
                    cfg_reg.manual_duration_ms <= pwdata[hfc_pkg::DUR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Read back; misaligned addresses read as zero.
    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'd0) begin
            unique case (paddr[3:2])
                hfc_pkg::REG_ON_THRESHOLD: begin
                    prdata = {17'd0, cfg_reg.on_threshold};
                end
                hfc_pkg::REG_HYSTERESIS: begin
                    prdata = {18'd0, cfg_reg.hysteresis};
                end
                hfc_pkg::REG_MANUAL_DUR: begin
                    prdata = {5'd0, cfg_reg.manual_duration_ms};
                end
                default: begin
                    prdata = 32'd0;
                end
            endcase
        end
    end

endmodule

@@ rtl/hfc_core.sv @@
`timescale 1ns / 1ps

module hfc_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             step,
    input  hfc_pkg::item_t   item,
    input  hfc_pkg::cfg_t    cfg,
    output hfc_pkg::result_t result
);

    logic                        fan_reg, fan_next;
    logic                        manual_reg, manual_next;
    logic                        stable_reg, stable_next;
    logic [hfc_pkg::SETTLE_W-1:0] settle_reg, settle_next;
    logic [hfc_pkg::SINCE_W-1:0]  since_reg, since_next;
    logic [hfc_pkg::DUR_W-1:0]    elapsed_reg, elapsed_next;

    logic                        send;
    logic                        fan_btn;
    logic                        manual_btn;
    logic [hfc_pkg::DUR_W-1:0]    elapsed_btn;
    logic signed [15:0]          diff;
    logic signed [16:0]          off_level;
    logic                        want_on;
    logic                        want_off;
    logic                        door_open;
    logic                        fan_auto;

    // Automatic rule: exact signed difference and off level.
    always_comb begin
        diff      = $signed({2'b00, item.inside_humidity})
                  - $signed({2'b00, item.outside_humidity});
        off_level = $signed({{2{cfg.on_threshold[hfc_pkg::THR_W-1]}}, cfg.on_threshold})
                  - $signed({3'b000, cfg.hysteresis});
        want_on   = diff > $signed({cfg.on_threshold[hfc_pkg::THR_W-1], cfg.on_threshold});
        want_off  = $signed({diff[15], diff}) < off_level;
        door_open = (item.door_status == hfc_pkg::DOOR_OPEN);
    end

    // Lockout counter and button debounce, with the manual toggle.
    always_comb begin
        since_next  = since_reg;
        settle_next = settle_reg;
        stable_next = stable_reg;
        manual_btn  = manual_reg;
        elapsed_btn = elapsed_reg;
        fan_btn     = fan_reg;
        send        = 1'b0;

        if (since_reg <= hfc_pkg::LOCKOUT_TICKS) begin
            since_next = since_reg + 1'b1;
        end

        if (settle_reg == '0) begin
            if (item.button_level != stable_reg) begin
                settle_next = hfc_pkg::SETTLE_TICKS;
            end
        end else begin
            settle_next = settle_reg - 1'b1;
            if (settle_next == '0 && item.button_level != stable_reg) begin
                stable_next = item.button_level;
                if (item.button_level && since_next > hfc_pkg::LOCKOUT_TICKS) begin
                    if (!manual_reg) begin
                        manual_btn  = 1'b1;
                        elapsed_btn = '0;
                        fan_btn     = 1'b1;
                    end else begin
                        manual_btn = 1'b0;
                    end
                    send       = 1'b1;
                    since_next = '0;
                end
            end
        end
    end

    // Fan state after the automatic rule, from the state left by the button.
    always_comb begin
        fan_auto = fan_btn;
        if (item.readings_valid) begin
            if (!fan_btn && want_on && !door_open) begin
                fan_auto = 1'b1;
            end else if (fan_btn && (want_off || door_open)) begin
                fan_auto = 1'b0;
            end
        end
    end

    // Manual timer, or the automatic rule when manual mode is off or ends.
    always_comb begin
        manual_next  = manual_btn;
        elapsed_next = elapsed_btn;
        fan_next     = fan_auto;
        if (manual_btn) begin
            if (elapsed_btn >= cfg.manual_duration_ms) begin
                manual_next = 1'b0;
            end else begin
                fan_next = 1'b1;
                if (elapsed_btn != '1) begin
                    elapsed_next = elapsed_btn + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fan_reg     <= 1'b0;
            manual_reg  <= 1'b0;
            stable_reg  <= 1'b0;
            settle_reg  <= '0;
            since_reg   <= hfc_pkg::LOCKOUT_TICKS + 1'b1;
            elapsed_reg <= '0;
        end else if (step) begin
            fan_reg     <= fan_next;
            manual_reg  <= manual_next;
            stable_reg  <= stable_next;
            settle_reg  <= settle_next;
            since_reg   <= since_next;
            elapsed_reg <= elapsed_next;
        end
    end

    assign result.fan_on       = fan_next;
    assign result.manual_mode  = manual_next;
    assign result.send_request = send;

endmodule

@@ rtl/humidity_fan_controller.sv @@
`timescale 1ns / 1ps

// Humidity fan controller. Each input beat is one 1 ms tick and yields exactly
// one result beat. A tick is held in an input register, evaluated by the
// combinational control logic (button debounce and lockout, manual timer,
// automatic humidity rule) and written to a result register. The throughput
// is one tick per cycle while the result side does not stall. The three
// settings sit on the APB port at byte addresses 0x0 (on_threshold), 0x4
// (hysteresis) and 0x8 (manual_duration_ms); the user must write them only
// while no tick is in flight, and the block itself does not enforce this.
module humidity_fan_controller (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [13:0] inside_humidity, [27:14] outside_humidity, [29:28] door_status,
    // [30] button_level, [31] zero
    input  logic [31:0] s_tdata,
    // [0] readings_valid
    input  logic        s_tuser,
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] fan_on, [1] manual_mode, [2] send_request, [7:3] zero
    output logic [7:0]  m_tdata,
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    hfc_pkg::cfg_t    cfg;
    hfc_pkg::item_t   item_reg;
    hfc_pkg::result_t core_result;
    hfc_pkg::result_t result_reg;
    logic             in_valid_reg;
    logic             out_valid_reg;
    logic             advance;

    hfc_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // A tick moves into the result register when that register is free or drains.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.inside_humidity  <= s_tdata[13:0];
            item_reg.outside_humidity <= s_tdata[27:14];
            item_reg.door_status      <= s_tdata[29:28];
            item_reg.button_level     <= s_tdata[30];
            item_reg.readings_valid   <= s_tuser;
        end
    end

    hfc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (core_result)
    );

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result_reg.send_request, result_reg.manual_mode,
                       result_reg.fan_on};

`ifndef NO_ASSERTIONS
    // Manual mode always drives the fan.
    a_manual_fan: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && result_reg.manual_mode |-> result_reg.fan_on)
        else $error("manual mode without fan on");

    // An empty result register never stalls the input side.
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty result register");

    // A tick that advances is presented on the result side next cycle.
    a_advance_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced tick not presented");

    // A toggle is reported only together with an accepted tick.
    a_send_once: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(result_reg.send_request) |-> $past(advance))
        else $error("send request without a tick");
`endif

endmodule

@@ tb/fan_checker.sv @@
`timescale 1ns / 1ps

// Watches the tick, result and register channels of the fan controller.
// Every accepted tick is run through a local copy of the control rules and
// the outcome is queued; every accepted result beat is compared against the
// oldest queued outcome.
module fan_checker
    import hfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output int          error_count,
    output int          pending,
    output int          ticks_checked,
    output int          toggles_seen,
    output int          auto_switches
);

    // Local copy of the register file and the controller state.
    cfg_t               settings;
    logic               fan_state;
    logic               manual_active;
    logic               stable_button;
    logic [SETTLE_W-1:0] settle_count;
    logic [SINCE_W-1:0]  since_press;
    logic [DUR_W-1:0]    manual_elapsed;

    result_t outcome_queue[$];

    initial begin
        error_count   = 0;
        pending       = 0;
        ticks_checked = 0;
        toggles_seen  = 0;
        auto_switches = 0;
    end

    // Prints one line per mismatch and counts it.
    task automatic report_mismatch(input string what, input int expv, input int gotv);
        error_count++;
        $display("mismatch at result %0d: %s expected %0d, got %0d",
                 ticks_checked, what, expv, gotv);
    endtask

    // Humidity rule: switch on above the threshold with the door shut,
    // switch off below the hysteresis band or when the door opens.
    function automatic void apply_humidity_rule(input item_t it);
        int   diff;
        int   thr_i;
        int   off_level;
        logic want_on;
        logic want_off;
        logic door_open;
        if (!it.readings_valid) return;
        diff      = int'(it.inside_humidity) - int'(it.outside_humidity);
        thr_i     = int'(settings.on_threshold);
        off_level = thr_i - int'(settings.hysteresis);
        want_on   = (diff > thr_i);
        want_off  = (diff < off_level);
        door_open = (it.door_status == DOOR_OPEN);
        if (!fan_state && want_on && !door_open) begin
            fan_state = 1'b1;
            auto_switches++;
        end else if (fan_state && (want_off || door_open)) begin
            fan_state = 1'b0;
            auto_switches++;
        end
    endfunction

    // Advances the controller by one tick and returns the result it drives.
    function automatic result_t advance_tick(input item_t it);
        result_t r;
        logic    toggled;
        toggled = 1'b0;
        if (since_press <= LOCKOUT_TICKS) since_press = since_press + 1'b1;

        // Debounce: start a recheck on a change, act when it expires.
        if (settle_count == '0) begin
            if (it.button_level != stable_button) settle_count = SETTLE_TICKS;
        end else begin
            settle_count = settle_count - 1'b1;
            if (settle_count == '0 && it.button_level != stable_button) begin
                stable_button = it.button_level;
                if (it.button_level && since_press > LOCKOUT_TICKS) begin
                    if (!manual_active) begin
                        manual_active  = 1'b1;
                        manual_elapsed = '0;
                        fan_state      = 1'b1;
                    end else begin
                        manual_active = 1'b0;
                    end
                    toggled     = 1'b1;
                    since_press = '0;
                end
            end
        end

        // Manual timer, or the humidity rule when not in manual mode.
        if (manual_active) begin
            if (manual_elapsed >= settings.manual_duration_ms) begin
                manual_active = 1'b0;
                apply_humidity_rule(it);
            end else begin
                fan_state = 1'b1;
                if (manual_elapsed != '1) manual_elapsed = manual_elapsed + 1'b1;
            end
        end else begin
            apply_humidity_rule(it);
        end

        if (toggled) toggles_seen++;
        r.fan_on       = fan_state;
        r.manual_mode  = manual_active;
        r.send_request = toggled;
        return r;
    endfunction

    always @(posedge aclk) begin
        item_t   it;
        result_t want;
        if (!aresetn) begin
            settings.on_threshold       = ON_THRESHOLD_RST;
            settings.hysteresis         = HYSTERESIS_RST;
            settings.manual_duration_ms = MANUAL_DUR_RST;
            fan_state      = 1'b0;
            manual_active  = 1'b0;
            stable_button  = 1'b0;
            settle_count   = '0;
            since_press    = LOCKOUT_TICKS + 1'b1;
            manual_elapsed = '0;
            outcome_queue.delete();
        end else begin
            // Register writes.
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_ON_THRESHOLD: settings.on_threshold       = pwdata[THR_W-1:0];
                    REG_HYSTERESIS:   settings.hysteresis         = pwdata[HYST_W-1:0];
                    REG_MANUAL_DUR:   settings.manual_duration_ms = pwdata[DUR_W-1:0];
                    default: ;
                endcase
            end

            // Result beats against the oldest outcome.
            if (m_tvalid && m_tready) begin
                if (outcome_queue.size() == 0) begin
                    report_mismatch("result beat with nothing outstanding, data", 0,
                                    int'(m_tdata));
                end else begin
                    want = outcome_queue.pop_front();
                    if (m_tdata[0] !== want.fan_on)
                        report_mismatch("fan_on", want.fan_on, m_tdata[0]);
                    if (m_tdata[1] !== want.manual_mode)
                        report_mismatch("manual_mode", want.manual_mode, m_tdata[1]);
                    if (m_tdata[2] !== want.send_request)
                        report_mismatch("send_request", want.send_request, m_tdata[2]);
                end
                ticks_checked++;
            end

            // Tick beats into the predictor.
            if (s_tvalid && s_tready) begin
                it.inside_humidity  = s_tdata[13:0];
                it.outside_humidity = s_tdata[27:14];
                it.door_status      = s_tdata[29:28];
                it.button_level     = s_tdata[30];
                it.readings_valid   = s_tuser;
                outcome_queue.push_back(advance_tick(it));
            end
        end
        pending = outcome_queue.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the humidity fan controller. The checker beside
// the block does all prediction and comparison.
module testbench;
    import hfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    int error_count;
    int pending;
    int ticks_checked;
    int toggles_seen;
    int auto_switches;

    // Stimulus shaping state.
    bit calm       = 1'b0;
    bit btn_level  = 1'b0;
    int btn_hold   = 0;
    int cur_thr    = 100;
    int cur_hyst   = 40;
    int stall_left = 0;
    int quiet_cycles = 0;
    int settings_used = 1;

    always #10 aclk = ~aclk;

    humidity_fan_controller i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fan_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .error_count   (error_count),
        .pending       (pending),
        .ticks_checked (ticks_checked),
        .toggles_seen  (toggles_seen),
        .auto_switches (auto_switches)
    );

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int gap_len();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side back-pressure.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left = stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 20) stall_left = gap_len();
        end
    end

    // Ends the run if no beat moves on either channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", quiet_cycles);
            $display("testbench NOT OK");
            $finish;
        end
    end

    // Presents one tick beat; entered and left just after a falling edge.
    task automatic push_tick(input logic [13:0] ins, input logic [13:0] outs,
                             input logic valid, input logic [1:0] door,
                             input logic btn);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, btn, door, outs, ins};
        s_tuser  <= valid;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // One APB write: setup cycle, access cycle, then back to idle.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
    endtask

    // Drain the block completely, then load a new set of registers.
    task automatic load_settings(input int thr, input int hyst, input int dur);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(REG_ON_THRESHOLD, 32'(thr));
        write_reg(REG_HYSTERESIS, 32'(hyst));
        write_reg(REG_MANUAL_DUR, 32'(dur));
        cur_thr  = thr;
        cur_hyst = hyst;
        settings_used++;
    endtask

    // A random tick: humidity mostly near the switching levels, button held
    // long enough to pass the recheck most of the time, with short glitches.
    task automatic random_tick();
        int         pick;
        int         diff;
        int         ins;
        int         outs;
        bit         wide;
        logic [1:0] door;
        logic       valid;
        if (btn_hold == 0) begin
            btn_level = ~btn_level;
            pick = $urandom_range(0, 99);
            if (pick < 75)      btn_hold = $urandom_range(11, 40);
            else if (pick < 90) btn_hold = $urandom_range(1, 10);
            else                btn_hold = $urandom_range(41, 120);
        end
        btn_hold--;

        wide = 1'b0;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            diff = cur_thr + int'($urandom_range(0, cur_hyst + 40)) - cur_hyst - 20;
        end else if (pick < 70) begin
            case ($urandom_range(0, 3))
                0:       diff = cur_thr;
                1:       diff = cur_thr + 1;
                2:       diff = cur_thr - cur_hyst;
                default: diff = cur_thr - cur_hyst - 1;
            endcase
        end else begin
            wide = 1'b1;
            diff = 0;
        end

        if (wide) begin
            ins  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                               : $urandom_range(0, 10000);
            outs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16383)
                                               : $urandom_range(0, 10000);
        end else begin
            if (diff > 16383)  diff = 16383;
            if (diff < -16383) diff = -16383;
            if (diff >= 0) begin
                outs = $urandom_range(0, 16383 - diff);
                ins  = outs + diff;
            end else begin
                ins  = $urandom_range(0, 16383 + diff);
                outs = ins - diff;
            end
        end

        door = 2'($urandom_range(0, 3));
        if (door == DOOR_OPEN && $urandom_range(0, 2) != 0) door = 2'($urandom_range(0, 1));
        valid = ($urandom_range(0, 9) != 0);
        push_tick(ins[13:0], outs[13:0], valid, door, btn_level);
    endtask

    task automatic run_phase(input int thr, input int hyst, input int dur,
                             input int count, input bit quiet);
        load_settings(thr, hyst, dur);
        calm = quiet;
        repeat (count) random_tick();
        calm = 1'b0;
    endtask

    initial begin
        int k;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed ticks with the reset settings (threshold 100, band 40).
        push_tick(14'd0,     14'd0,     1'b1, 2'd0,      1'b0);
        push_tick(14'd16383, 14'd0,     1'b1, 2'd1,      1'b0);  // far above: on
        push_tick(14'd16383, 14'd0,     1'b1, DOOR_OPEN, 1'b0);  // door opens: off
        push_tick(14'd16383, 14'd0,     1'b0, 2'd0,      1'b0);  // invalid: held off
        push_tick(14'd10000, 14'd0,     1'b1, 2'd3,      1'b0);  // on again
        push_tick(14'd0,     14'd16383, 1'b0, 2'd0,      1'b0);  // invalid: held on
        push_tick(14'd160,   14'd100,   1'b1, 2'd0,      1'b0);  // at off level: held
        push_tick(14'd159,   14'd100,   1'b1, 2'd0,      1'b0);  // just below: off
        push_tick(14'd200,   14'd100,   1'b1, 2'd0,      1'b0);  // at threshold: held
        push_tick(14'd201,   14'd100,   1'b1, 2'd0,      1'b0);  // just above: on
        push_tick(14'd0,     14'd16383, 1'b1, 2'd0,      1'b0);  // far below: off
        // A press held through the recheck starts manual mode.
        for (k = 0; k < 11; k++) push_tick(14'd0, 14'd0, 1'b1, 2'd0, 1'b1);
        push_tick(14'd0, 14'd0, 1'b1, 2'd0, 1'b0);
        push_tick(14'd0, 14'd0, 1'b1, 2'd0, 1'b0);

        // Random ticks across several register settings, extremes included.
        run_phase(100,    40,    30,           250, 1'b0);
        run_phase(-10000, 0,     0,            120, 1'b0);
        run_phase(10000,  10000, 1,            120, 1'b0);
        run_phase(-16384, 16383, 86400000,     120, 1'b1);
        run_phase(16383,  0,     27'h7FFFFFF,  100, 1'b0);
        run_phase(0,      5,     80,           250, 1'b0);
        repeat (3) begin
            run_phase(int'($urandom_range(0, 600)) - 300, $urandom_range(0, 200),
                      $urandom_range(0, 120), 130, 1'b0);
        end

        // Drain and give the verdict.
        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(posedge aclk);
        $display("Covered %0d ticks under %0d register settings.", ticks_checked,
                 settings_used);
        $display("Predicted %0d manual toggles and %0d automatic fan switches.",
                 toggles_seen, auto_switches);
        if (error_count == 0 && pending == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hfc_pkg.sv
rtl/hfc_cfg_regs.sv
rtl/hfc_core.sv
rtl/humidity_fan_controller.sv
tb/fan_checker.sv
tb/testbench.sv
